// ----- rtl/scpr_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the second-chance page replacement block.
// Holds the controller/datapath command and status structs and the register map.
// No dependencies.
package scpr_pkg;

    // Width of the running request and fault counters
    localparam int CNT_BITS = 32;

    // Register port geometry: one 32-bit register, word-aligned byte addresses
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    // Word index of each register (paddr bits above the byte offset)
    localparam logic [PADDR_W-3:0] REG_FRAMES_IN_USE = '0;

    // Commands from the controller to the datapath; at most one per cycle
    typedef struct packed {
        logic start;     // latch request, rewind scan, count request
        logic search;    // read next frame tag, compare previous one
        logic take_hit;  // record matching frame as result
        logic miss;      // count fault, wrap hand into range
        logic sweep;     // clear reference bit at hand, advance hand
        logic victim;    // pick frame at hand, read its old page
        logic finish;    // update frame state, load result register
    } t_dp_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic match;        // compared frame is valid and holds the page
        logic search_done;  // all frames in use compared, no match
        logic hand_ref;     // reference bit at the hand is set
        logic out_free;     // result register can take a new result
    } t_dp_sts;

endpackage

// ----- rtl/scpr_ctrl.sv -----
`timescale 1ns / 1ps
// Controller state machine for the second-chance page replacement block.
// Sequences lookup, sweep and fill; depends on scpr_pkg for command/status types.
module scpr_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  scpr_pkg::t_dp_sts i_sts,
    output scpr_pkg::t_dp_cmd o_cmd
);
    import scpr_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SEARCH = 3'd1;
    localparam logic [2:0] ST_SWEEP  = 3'd2;
    localparam logic [2:0] ST_FINISH = 3'd3;

    logic [2:0] r_state;
    logic [2:0] n_state;
    t_dp_cmd    cmd;

    // Next state and command decode
    always_comb begin
        n_state = r_state;
        cmd     = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    cmd.start = 1'b1;
                    n_state   = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                if (i_sts.match) begin
                    cmd.take_hit = 1'b1;
                    n_state      = ST_FINISH;
                end else if (i_sts.search_done) begin
                    cmd.miss = 1'b1;
                    n_state  = ST_SWEEP;
                end else begin
                    cmd.search = 1'b1;
                end
            end
            ST_SWEEP: begin
                if (i_sts.hand_ref) begin
                    cmd.sweep = 1'b1;
                end else begin
                    cmd.victim = 1'b1;
                    n_state    = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (i_sts.out_free) begin
                    cmd.finish = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd      = cmd;
    assign o_in_stall = (r_state != ST_IDLE);

endmodule

// ----- rtl/scpr_dp.sv -----
`timescale 1ns / 1ps
// Datapath for the second-chance page replacement block: page tag memory,
// valid and reference bits, clock hand, counters and result register. Uses scpr_pkg.
module scpr_dp #(
    parameter int MAX_FRAMES = 16,
    parameter int PAGE_BITS  = 16,
    localparam int IDX_W     = $clog2(MAX_FRAMES),
    localparam int CNT_W     = $clog2(MAX_FRAMES + 1)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [CNT_W-1:0]              i_frames_in_use,
    input  logic [PAGE_BITS-1:0]          i_page_number,
    input  scpr_pkg::t_dp_cmd             i_cmd,
    output scpr_pkg::t_dp_sts             o_sts,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_hit,
    output logic [IDX_W-1:0]              o_frame_index,
    output logic                          o_evicted_valid,
    output logic [PAGE_BITS-1:0]          o_evicted_page,
    output logic [scpr_pkg::CNT_BITS-1:0] o_request_count,
    output logic [scpr_pkg::CNT_BITS-1:0] o_fault_count
);
    import scpr_pkg::*;

    // Page tag memory, undefined until written
    logic [PAGE_BITS-1:0]  r_page_mem [MAX_FRAMES];

    logic [MAX_FRAMES-1:0] r_valid;
    logic [MAX_FRAMES-1:0] r_ref;
    logic [IDX_W-1:0]      r_hand;
    logic [CNT_BITS-1:0]   r_req_cnt;
    logic [CNT_BITS-1:0]   r_flt_cnt;
    logic [CNT_W-1:0]      r_scan;
    logic                  r_rd_live;
    logic [IDX_W-1:0]      r_rd_idx;
    logic [PAGE_BITS-1:0]  r_rd_data;
    logic [PAGE_BITS-1:0]  r_page;
    logic [IDX_W-1:0]      r_sel;
    logic                  r_hit;
    logic                  r_out_valid;
    logic                  r_o_hit;
    logic [IDX_W-1:0]      r_o_frame;
    logic                  r_o_ev_valid;
    logic [PAGE_BITS-1:0]  r_o_ev_page;
    logic [CNT_BITS-1:0]   r_o_req;
    logic [CNT_BITS-1:0]   r_o_flt;

    logic [CNT_W-1:0]      n_act;
    logic                  scan_more;
    logic [CNT_W-1:0]      hand_inc;
    logic [IDX_W-1:0]      hand_next;
    logic [CNT_W-1:0]      sel_inc;
    logic [IDX_W-1:0]      sel_next;
    logic                  hand_out;
    logic                  rd_en;
    logic [IDX_W-1:0]      rd_addr;
    logic                  evict;

    // Clamp frame count into 1..MAX_FRAMES
    always_comb begin
        if (i_frames_in_use == '0) begin
            n_act = CNT_W'(1);
        end else if (i_frames_in_use > CNT_W'(MAX_FRAMES)) begin
            n_act = CNT_W'(MAX_FRAMES);
        end else begin
            n_act = i_frames_in_use;
        end
    end

    // Hand arithmetic with wrap at the frame count
    assign hand_inc  = CNT_W'(r_hand) + CNT_W'(1);
    assign hand_next = (hand_inc >= n_act) ? '0 : hand_inc[IDX_W-1:0];
    assign sel_inc   = CNT_W'(r_sel) + CNT_W'(1);
    assign sel_next  = (sel_inc >= n_act) ? '0 : sel_inc[IDX_W-1:0];
    assign hand_out  = (CNT_W'(r_hand) >= n_act);
    assign scan_more = (r_scan < n_act);

    // Memory read port: scan during lookup, hand when picking a victim
    assign rd_en   = (i_cmd.search && scan_more) || i_cmd.victim;
    assign rd_addr = i_cmd.victim ? r_hand : r_scan[IDX_W-1:0];
    assign evict   = !r_hit && r_valid[r_sel];

    // Status to the controller
    assign o_sts.match       = r_rd_live && r_valid[r_rd_idx] && (r_rd_data == r_page);
    assign o_sts.search_done = !r_rd_live && (r_scan == n_act);
    assign o_sts.hand_ref    = r_ref[r_hand];
    assign o_sts.out_free    = !r_out_valid || !i_out_stall;

    // Tag memory: write on fill, registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish && !r_hit) begin
            r_page_mem[r_sel] <= r_page;
        end
        if (rd_en) begin
            r_rd_data <= r_page_mem[rd_addr];
        end
    end

    // Control state: frame bits, hand, counters, scan, result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_ref       <= '0;
            r_hand      <= '0;
            r_req_cnt   <= '0;
            r_flt_cnt   <= '0;
            r_scan      <= '0;
            r_rd_live   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.start) begin
                r_scan    <= '0;
                r_rd_live <= 1'b0;
                r_req_cnt <= r_req_cnt + CNT_BITS'(1);
            end
            if (i_cmd.search) begin
                r_rd_live <= scan_more;
                if (scan_more) begin
                    r_scan <= r_scan + CNT_W'(1);
                end
            end
            if (i_cmd.miss) begin
                r_flt_cnt <= r_flt_cnt + CNT_BITS'(1);
                if (hand_out) begin
                    r_hand <= '0;
                end
            end
            // Give the frame at the hand its second chance
            if (i_cmd.sweep) begin
                r_ref[r_hand] <= 1'b0;
                r_hand        <= hand_next;
            end
            if (i_cmd.finish) begin
                if (r_hit) begin
                    r_ref[r_sel] <= 1'b1;
                end else begin
                    r_valid[r_sel] <= 1'b1;
                    r_ref[r_sel]   <= 1'b0;
                    r_hand         <= sel_next;
                end
            end
            // Result register: load on finish, drop when taken
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Request and result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_page <= i_page_number;
        end
        if (i_cmd.search) begin
            r_rd_idx <= r_scan[IDX_W-1:0];
        end
        if (i_cmd.take_hit) begin
            r_sel <= r_rd_idx;
            r_hit <= 1'b1;
        end
        if (i_cmd.miss) begin
            r_hit <= 1'b0;
        end
        if (i_cmd.victim) begin
            r_sel <= r_hand;
        end
        if (i_cmd.finish) begin
            r_o_hit      <= r_hit;
            r_o_frame    <= r_sel;
            r_o_ev_valid <= evict;
            r_o_ev_page  <= evict ? r_rd_data : '0;
            r_o_req      <= r_req_cnt;
            r_o_flt      <= r_flt_cnt;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_hit           = r_o_hit;
    assign o_frame_index   = r_o_frame;
    assign o_evicted_valid = r_o_ev_valid;
    assign o_evicted_page  = r_o_ev_page;
    assign o_request_count = r_o_req;
    assign o_fault_count   = r_o_flt;

    // The controller never issues two commands at once
    a_cmd_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(i_cmd))
        else $error("scpr_dp: more than one command in a cycle");

    // A sweep step only passes over a referenced frame
    a_sweep_ref: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.sweep |-> r_ref[r_hand])
        else $error("scpr_dp: sweep over a clear reference bit");

    // The victim always has its reference bit clear
    a_victim_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.victim |-> !r_ref[r_hand])
        else $error("scpr_dp: victim with reference bit set");

    // After a fault starts, the hand lies inside the frames in use
    a_hand_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.miss |=> (CNT_W'(r_hand) < n_act))
        else $error("scpr_dp: hand outside frames in use");

    // A finished request always lands in the result register
    a_finish_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |=> r_out_valid)
        else $error("scpr_dp: result register not loaded");

endmodule

// ----- rtl/second_chance_page_replacement.sv -----
`timescale 1ns / 1ps
// Top level of the second-chance (clock) page replacement block: register port
// and the controller/datapath pair. Uses scpr_pkg, scpr_ctrl and scpr_dp.
//
//   channel  direction  handshake                 payload
//   in       input      i_in_valid / o_in_stall   i_page_number
//   out      output     o_out_valid / i_out_stall o_hit, o_frame_index, o_evicted_valid,
//                                                 o_evicted_page, o_request_count,
//                                                 o_fault_count
//   config   APB        psel/penable/pwrite/pready  frames_in_use at byte address 0
//
// One request at a time. A lookup scans the tag memory one entry per cycle, and a
// fault then sweeps the hand one frame per cycle, clearing s reference bits (s <= n,
// n the frames in use) before it picks the victim.
// Synchronous active-low reset empties all frames, zeroes hand and counters and sets
// frames_in_use to MAX_FRAMES. A new request is taken while a result waits; a
// stalled result holds, and the next result waits for it to be taken.
module second_chance_page_replacement #(
    parameter int MAX_FRAMES = 16,
    parameter int PAGE_BITS  = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic [PAGE_BITS-1:0]                 i_page_number,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic                                 o_hit,
    output logic [$clog2(MAX_FRAMES)-1:0]        o_frame_index,
    output logic                                 o_evicted_valid,
    output logic [PAGE_BITS-1:0]                 o_evicted_page,
    output logic [scpr_pkg::CNT_BITS-1:0]        o_request_count,
    output logic [scpr_pkg::CNT_BITS-1:0]        o_fault_count,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [scpr_pkg::PADDR_W-1:0]         paddr,
    input  logic [scpr_pkg::PDATA_W-1:0]         pwdata,
    output logic [scpr_pkg::PDATA_W-1:0]         prdata,
    output logic                                 pready
);
    import scpr_pkg::*;

    localparam int CNT_W = $clog2(MAX_FRAMES + 1);

    logic [CNT_W-1:0] r_frames_in_use;
    logic             reg_hit;
    t_dp_cmd          cmd;
    t_dp_sts          sts;

    // Register decode on the word index
    assign reg_hit = (paddr[PADDR_W-1:2] == REG_FRAMES_IN_USE);
    assign pready  = 1'b1;
    assign prdata  = reg_hit ? PDATA_W'(r_frames_in_use) : '0;

    // Frame count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frames_in_use <= CNT_W'(MAX_FRAMES);
        end else if (psel && penable && pwrite && pready && reg_hit) begin
            r_frames_in_use <= pwdata[CNT_W-1:0];
        end
    end

    scpr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    scpr_dp #(
        .MAX_FRAMES (MAX_FRAMES),
        .PAGE_BITS  (PAGE_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_frames_in_use (r_frames_in_use),
        .i_page_number   (i_page_number),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_hit           (o_hit),
        .o_frame_index   (o_frame_index),
        .o_evicted_valid (o_evicted_valid),
        .o_evicted_page  (o_evicted_page),
        .o_request_count (o_request_count),
        .o_fault_count   (o_fault_count)
    );

endmodule

// ----- dv/scpr_checker.sv -----
`timescale 1ns / 1ps
// Scoreboard for the second-chance page replacement block: snoops the register port
// and both channels, predicts every result and compares it field by field.
// Depends on scpr_pkg for the register map and the counter width.
module scpr_checker #(
    parameter int MAX_FRAMES = 16,
    parameter int PAGE_BITS  = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_stall,
    input  logic [PAGE_BITS-1:0]          i_page_number,
    input  logic                          i_out_valid,
    input  logic                          i_out_stall,
    input  logic                          i_hit,
    input  logic [$clog2(MAX_FRAMES)-1:0] i_frame_index,
    input  logic                          i_evicted_valid,
    input  logic [PAGE_BITS-1:0]          i_evicted_page,
    input  logic [scpr_pkg::CNT_BITS-1:0] i_request_count,
    input  logic [scpr_pkg::CNT_BITS-1:0] i_fault_count,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [scpr_pkg::PADDR_W-1:0]  paddr,
    input  logic [scpr_pkg::PDATA_W-1:0]  pwdata,
    input  logic                          pready,
    output int                            o_outstanding,
    output int                            o_fail_count
);
    import scpr_pkg::*;

    localparam int FRAME_W    = $clog2(MAX_FRAMES);
    localparam int MAX_REPORT = 10;

    typedef struct packed {
        logic                hit;
        logic [FRAME_W-1:0]  frame;
        logic                ev_valid;
        logic [PAGE_BITS-1:0] ev_page;
        logic [CNT_BITS-1:0] req_cnt;
        logic [CNT_BITS-1:0] flt_cnt;
    } t_page_result;

    // Shadow of the block's replacement state
    logic [4:0]           frames_cfg;
    logic [PAGE_BITS-1:0] frame_tag     [MAX_FRAMES];
    logic                 resident      [MAX_FRAMES];
    logic                 ref_flag      [MAX_FRAMES];
    int                   hand;
    logic [CNT_BITS-1:0]  req_seen;
    logic [CNT_BITS-1:0]  flt_seen;

    t_page_result         pending_results [$];
    t_page_result         want;
    t_page_result         got;
    int                   fail_count;
    int                   results_seen;

    // Advance the shadow state by one request and return the result it gives
    function automatic t_page_result predict_lookup(input logic [PAGE_BITS-1:0] pg);
        int           n;
        int           k;
        t_page_result r;
        n = (frames_cfg == 0) ? 1 : ((frames_cfg > MAX_FRAMES) ? MAX_FRAMES : int'(frames_cfg));
        r = '0;
        req_seen = req_seen + 1'b1;
        // lowest matching frame wins when a page sits in two frames
        for (k = 0; k < n; k++) begin
            if (!r.hit && resident[k] && frame_tag[k] == pg) begin
                r.hit   = 1'b1;
                r.frame = FRAME_W'(k);
            end
        end
        if (r.hit) begin
            ref_flag[r.frame] = 1'b1;
        end else begin
            flt_seen = flt_seen + 1'b1;
            if (hand >= n) hand = 0;
            // sweep: clear set bits until a frame with a clear reference bit turns up
            while (ref_flag[hand]) begin
                ref_flag[hand] = 1'b0;
                hand = (hand + 1 >= n) ? 0 : hand + 1;
            end
            r.frame = FRAME_W'(hand);
            if (resident[hand]) begin
                r.ev_valid = 1'b1;
                r.ev_page  = frame_tag[hand];
            end
            frame_tag[hand] = pg;
            resident[hand]  = 1'b1;
            ref_flag[hand]  = 1'b0;
            hand = (hand + 1 >= n) ? 0 : hand + 1;
        end
        r.req_cnt = req_seen;
        r.flt_cnt = flt_seen;
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            frames_cfg = 5'(MAX_FRAMES);
            for (int k = 0; k < MAX_FRAMES; k++) begin
                frame_tag[k] = '0;
                resident[k]  = 1'b0;
                ref_flag[k]  = 1'b0;
            end
            hand     = 0;
            req_seen = '0;
            flt_seen = '0;
            pending_results.delete();
        end else begin
            // track register writes
            if (psel && penable && pwrite && pready
                    && paddr[PADDR_W-1:2] == REG_FRAMES_IN_USE) begin
                frames_cfg = pwdata[4:0];
            end
            // predict each accepted request
            if (i_in_valid && !i_in_stall) begin
                pending_results.push_back(predict_lookup(i_page_number));
            end
            // compare each accepted result with the oldest prediction
            if (i_out_valid && !i_out_stall) begin
                results_seen++;
                got = '{i_hit, i_frame_index, i_evicted_valid, i_evicted_page,
                        i_request_count, i_fault_count};
                if (pending_results.size() == 0) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORT)
                        $display("result %0d arrived with no request pending", results_seen);
                end else begin
                    want = pending_results.pop_front();
                    if (got.hit !== want.hit || got.frame !== want.frame
                            || got.ev_valid !== want.ev_valid || got.ev_page !== want.ev_page
                            || got.req_cnt !== want.req_cnt || got.flt_cnt !== want.flt_cnt) begin
                        fail_count++;
                        if (fail_count <= MAX_REPORT) begin
                            $display("result %0d expected hit=%0d frame=%0d ev=%0d/%h req=%0d flt=%0d",
                                     results_seen, want.hit, want.frame, want.ev_valid,
                                     want.ev_page, want.req_cnt, want.flt_cnt);
                            $display("result %0d actual   hit=%0d frame=%0d ev=%0d/%h req=%0d flt=%0d",
                                     results_seen, got.hit, got.frame, got.ev_valid,
                                     got.ev_page, got.req_cnt, got.flt_cnt);
                        end
                    end
                end
            end
        end
        o_outstanding = pending_results.size();
        o_fail_count  = fail_count;
    end

endmodule

// ----- dv/second_chance_page_replacement_tb.sv -----
`timescale 1ns / 1ps
// Top of the page replacement testbench: clock, reset, register writes, page requests
// and result back-pressure, with the verdict. Depends on scpr_pkg, scpr_checker
// and the second_chance_page_replacement block.
module second_chance_page_replacement_tb;
    import scpr_pkg::*;

    localparam int MAX_FRAMES       = 16;
    localparam int PAGE_BITS        = 16;
    localparam int FRAME_W          = $clog2(MAX_FRAMES);
    localparam int PHASES           = 8;
    localparam int ITEMS_PER_PHASE  = 100;
    localparam int SETTLE_CYCLES    = 40;
    localparam int LONG_HOLD_CYCLES = 300;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic [PAGE_BITS-1:0] i_page_number;
    logic                 o_out_valid;
    logic                 i_out_stall;
    logic                 o_hit;
    logic [FRAME_W-1:0]   o_frame_index;
    logic                 o_evicted_valid;
    logic [PAGE_BITS-1:0] o_evicted_page;
    logic [CNT_BITS-1:0]  o_request_count;
    logic [CNT_BITS-1:0]  o_fault_count;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [PDATA_W-1:0]   pwdata;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    int                   outstanding;
    int                   fail_count;
    bit                   quiet;
    bit                   long_hold;

    // frame counts per random phase, out-of-range values included
    int                   frame_plan [PHASES] = '{16, 1, 8, 17, 3, 31, 2, 16};

    second_chance_page_replacement #(
        .MAX_FRAMES (MAX_FRAMES),
        .PAGE_BITS  (PAGE_BITS)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_page_number   (i_page_number),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_hit           (o_hit),
        .o_frame_index   (o_frame_index),
        .o_evicted_valid (o_evicted_valid),
        .o_evicted_page  (o_evicted_page),
        .o_request_count (o_request_count),
        .o_fault_count   (o_fault_count),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    scpr_checker #(
        .MAX_FRAMES (MAX_FRAMES),
        .PAGE_BITS  (PAGE_BITS)
    ) u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_in_stall      (o_in_stall),
        .i_page_number   (i_page_number),
        .i_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .i_hit           (o_hit),
        .i_frame_index   (o_frame_index),
        .i_evicted_valid (o_evicted_valid),
        .i_evicted_page  (o_evicted_page),
        .i_request_count (o_request_count),
        .i_fault_count   (o_fault_count),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .pready          (pready),
        .o_outstanding   (outstanding),
        .o_fail_count    (fail_count)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Offer one request, with an occasional gap first; hold it until accepted
    task automatic send_page(input logic [PAGE_BITS-1:0] pg);
        @(negedge i_clk);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_page_number <= pg;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // Drop valid and wait until every predicted result has been taken
    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (outstanding != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Write the frame count through the register port once the block is idle
    task automatic set_frames(input logic [4:0] count);
        drain();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_FRAMES_IN_USE, 2'b00};
        pwdata  <= PDATA_W'(count);
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Result back-pressure: random stall bursts, one long hold on request
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (long_hold) begin
                long_hold = 1'b0;
                i_out_stall <= 1'b1;
                repeat (LONG_HOLD_CYCLES) @(negedge i_clk);
            end else if (!quiet && $urandom_range(0, 2) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 19) - 1) @(negedge i_clk);
            end else begin
                i_out_stall <= 1'b0;
                repeat ($urandom_range(1, 19) - 1) @(negedge i_clk);
            end
        end
    end

    // Stimulus and verdict
    initial begin
        int                   ph;
        int                   k;
        int                   eff;
        int                   span;
        logic [PAGE_BITS-1:0] pool_base;
        logic [PAGE_BITS-1:0] pg;

        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_page_number = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        quiet         = 1'b0;
        long_hold     = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // page number extremes, then hits on both
        send_page(16'h0000);
        send_page(16'hFFFF);
        send_page(16'h0000);
        send_page(16'hFFFF);
        send_page(16'hAAAA);
        send_page(16'h5555);

        // shrink below the hand: the next fault wraps the hand and sweeps both frames
        set_frames(5'd2);
        send_page(16'h1234);
        send_page(16'hFFFF);
        send_page(16'h4321);

        // a count of zero manages one frame
        set_frames(5'd0);
        send_page(16'h0F0F);
        send_page(16'h0F0F);
        send_page(16'h5555);

        // oversize count manages all frames; 0x5555 now sits in two frames
        set_frames(5'd31);
        send_page(16'h5555);
        send_page(16'hAAAA);
        send_page(16'hBEEF);
        send_page(16'h0001);

        // random phases: a working set a bit larger than the frames, plus stray pages
        for (ph = 0; ph < PHASES; ph++) begin
            set_frames(5'(frame_plan[ph]));
            if (ph == PHASES - 1) quiet = 1'b1;
            if (ph == 0) long_hold = 1'b1;
            eff = (frame_plan[ph] == 0) ? 1
                : ((frame_plan[ph] > MAX_FRAMES) ? MAX_FRAMES : frame_plan[ph]);
            span      = eff + eff / 2;
            pool_base = PAGE_BITS'($urandom);
            for (k = 0; k < ITEMS_PER_PHASE; k++) begin
                if ($urandom_range(0, 7) == 0)
                    pg = PAGE_BITS'($urandom);
                else
                    pg = pool_base + PAGE_BITS'($urandom_range(0, span));
                send_page(pg);
            end
        end
        drain();

        if (fail_count == 0 && outstanding == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #4_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

// ----- second_chance_page_replacement.f -----
rtl/scpr_pkg.sv
rtl/scpr_ctrl.sv
rtl/scpr_dp.sv
rtl/second_chance_page_replacement.sv
dv/scpr_checker.sv
dv/second_chance_page_replacement_tb.sv
